[hw/rtl/csce_pkg.sv]
// ----------------------------------------------------------------------------
// csce_pkg
// Shared types and constants of the stack command encoder.
// ----------------------------------------------------------------------------
package csce_pkg;

  typedef enum logic [3:0] {
    OP_WR16    = 4'd0,
    OP_WR24    = 4'd1,
    OP_RD16    = 4'd2,
    OP_RD24    = 4'd3,
    OP_CTRL    = 4'd4,
    OP_QSTOP16 = 4'd5,
    OP_QSTOP24 = 4'd6,
    OP_QSCAN   = 4'd7,
    OP_REPEAT  = 4'd8,
    OP_MARKER  = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_SLOT    = 2'd1,
    ERR_SUBADDR = 2'd2,
    ERR_FUNC    = 2'd3
  } err_e;

  localparam logic [15:0] ContBit    = 16'h8000;
  localparam logic [15:0] LongBit    = 16'h4000;
  localparam logic [15:0] ModeLam    = 16'h0080;
  localparam logic [15:0] ModeQstop  = 16'h0010;
  localparam logic [15:0] ModeQscan  = 16'h0020;
  localparam logic [15:0] ModeRepeat = 16'h0040;
  localparam logic [15:0] MarkerNaf  = 16'h0010;

  localparam logic [4:0] SlotLimit    = 5'd30;
  localparam logic [4:0] SubaddrLimit = 5'd16;

  // One encoded command: up to three stack words, the number of words
  // and the error code that goes with every word.
  typedef struct packed {
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [1:0]  len;
    err_e        err;
  } cmd_t;

endpackage

[hw/rtl/camac_stack_command_encoder_top.sv]
// ----------------------------------------------------------------------------
// camac_stack_command_encoder_top
// Turns one dataway command into its 16-bit controller stack words.
// ----------------------------------------------------------------------------
// A command is transferred in at a rising edge where start is high and
// busy is low. The front checks slot, subaddress and function code and
// encodes the command into one to three stack words; a failed check gives
// a single zero word with last_word_o set and the error code of the first
// failing check. Undefined opcodes are dropped and give no words.
// Encoded commands wait in a short queue (QueueDepth entries) and the back
// sends them out as one word per cycle on stack_word_o, each marked by
// valid_o for exactly one cycle; the receiver has no way to stall.
// With the queue empty, the first word's strobe follows the accepting
// edge through the queue, the back's command register and its output
// register. Throughput, set by the single word-wide output register, is
// one word per cycle while commands are queued. busy rises only when full.
// Reset empties the queue and drops any command in flight; no word is
// sent after reset until a new command arrives.
// ----------------------------------------------------------------------------
module camac_stack_command_encoder_top import csce_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  opcode_i,
  input  logic [4:0]  slot_i,
  input  logic [4:0]  subaddress_i,
  input  logic [4:0]  function_code_i,
  input  logic [31:0] write_data_i,
  input  logic [15:0] transfer_count_i,
  input  logic        lam_wait_i,
  output logic        valid_o,
  output logic [15:0] stack_word_o,
  output logic        last_word_o,
  output logic [1:0]  error_code_o
);

  logic push;
  logic pop;
  logic empty;
  logic full;
  cmd_t cmd;
  cmd_t head;

  // The queue being full is the only reason to hold off a transfer.
  assign busy = full;

  csce_front u_front (
    .start_i          (start),
    .full_i           (full),
    .opcode_i         (opcode_i),
    .slot_i           (slot_i),
    .subaddress_i     (subaddress_i),
    .function_code_i  (function_code_i),
    .write_data_i     (write_data_i),
    .transfer_count_i (transfer_count_i),
    .lam_wait_i       (lam_wait_i),
    .push_o           (push),
    .cmd_o            (cmd)
  );

  csce_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  csce_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .valid_o      (valid_o),
    .stack_word_o (stack_word_o),
    .last_word_o  (last_word_o),
    .error_code_o (error_code_o)
  );

endmodule

[hw/rtl/csce_front.sv]
// ----------------------------------------------------------------------------
// csce_front
// Checks one command and encodes it into its list of stack words.
// ----------------------------------------------------------------------------
module csce_front import csce_pkg::*; (
  input  logic        start_i,
  input  logic        full_i,
  input  logic [3:0]  opcode_i,
  input  logic [4:0]  slot_i,
  input  logic [4:0]  subaddress_i,
  input  logic [4:0]  function_code_i,
  input  logic [31:0] write_data_i,
  input  logic [15:0] transfer_count_i,
  input  logic        lam_wait_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  op_e         op;
  logic        func_ok;
  logic [15:0] naf;
  logic [15:0] mode;

  assign op  = op_e'(opcode_i);
  assign naf = {2'b00, slot_i, subaddress_i[3:0], function_code_i};

  always_comb begin
    case (op)
      OP_WR16, OP_WR24: func_ok = function_code_i inside {[5'd16:5'd23]};
      OP_CTRL:          func_ok = function_code_i inside {[5'd8:5'd15], [5'd24:5'd31]};
      default:          func_ok = function_code_i inside {[5'd0:5'd7]};
    endcase
  end

  always_comb begin
    case (op)
      OP_QSCAN:  mode = ModeQscan;
      OP_REPEAT: mode = ModeRepeat;
      default:   mode = ModeQstop;
    endcase
    mode = mode | ContBit | (lam_wait_i ? ModeLam : 16'h0000);
  end

  always_comb begin
    cmd_o = '{w0: 16'h0000, w1: 16'h0000, w2: 16'h0000, len: 2'd1, err: ERR_OK};
    if (op > OP_MARKER) begin
      // Undefined opcodes skip every check and give no words at all.
      cmd_o.len = 2'd0;
    end else if (op != OP_MARKER && slot_i >= SlotLimit) begin
      cmd_o.err = ERR_SLOT;
    end else if (op != OP_MARKER && subaddress_i >= SubaddrLimit) begin
      cmd_o.err = ERR_SUBADDR;
    end else if (op != OP_MARKER && !func_ok) begin
      cmd_o.err = ERR_FUNC;
    end else begin
      case (op)
        OP_WR16: begin
          cmd_o.w0  = naf;
          cmd_o.w1  = write_data_i[15:0];
          cmd_o.len = 2'd2;
        end
        OP_WR24: begin
          cmd_o.w0  = naf | LongBit;
          cmd_o.w1  = write_data_i[15:0];
          cmd_o.w2  = write_data_i[31:16];
          cmd_o.len = 2'd3;
        end
        OP_RD16, OP_RD24: begin
          cmd_o.w0 = naf | ((op == OP_RD24) ? LongBit : 16'h0000);
          if (lam_wait_i) begin
            cmd_o.w0  = cmd_o.w0 | ContBit;
            cmd_o.w1  = ModeLam;
            cmd_o.len = 2'd2;
          end
        end
        OP_CTRL: begin
          cmd_o.w0 = naf;
        end
        OP_QSTOP16, OP_QSTOP24, OP_QSCAN, OP_REPEAT: begin
          cmd_o.w0  = naf | ContBit | ((op == OP_QSTOP24) ? LongBit : 16'h0000);
          cmd_o.w1  = mode;
          cmd_o.w2  = transfer_count_i;
          cmd_o.len = 2'd3;
        end
        OP_MARKER: begin
          cmd_o.w0  = MarkerNaf;
          cmd_o.w1  = write_data_i[15:0];
          cmd_o.len = 2'd2;
        end
        default: begin
          cmd_o.len = 2'd0;
        end
      endcase
    end
  end

  // Undefined opcodes give no words and are dropped here.
  assign push_o = start_i && !full_i && (cmd_o.len != 2'd0);

endmodule

[hw/rtl/csce_queue.sv]
// ----------------------------------------------------------------------------
// csce_queue
// Small command queue between the encoder front and the word sequencer.
// ----------------------------------------------------------------------------
module csce_queue import csce_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o,
  output logic full_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(Depth));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[hw/rtl/csce_back.sv]
// ----------------------------------------------------------------------------
// csce_back
// Sends the words of each queued command, one word per cycle.
// ----------------------------------------------------------------------------
module csce_back import csce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        valid_o,
  output logic [15:0] stack_word_o,
  output logic        last_word_o,
  output logic [1:0]  error_code_o
);

  cmd_t        cur_q;
  logic        active_q;
  logic [1:0]  idx_q;
  logic        at_last;
  logic [15:0] word;

  logic        valid_q;
  logic [15:0] stack_word_q;
  logic        last_word_q;
  logic [1:0]  error_code_q;

  assign at_last = (idx_q == cur_q.len - 2'd1);
  assign pop_o   = !empty_i && (!active_q || at_last);

  always_comb begin
    case (idx_q)
      2'd0:    word = cur_q.w0;
      2'd1:    word = cur_q.w1;
      default: word = cur_q.w2;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= active_q;
      if (pop_o) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (active_q) begin
        if (at_last) begin
          active_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (active_q) begin
      stack_word_q <= word;
      last_word_q  <= at_last;
      error_code_q <= cur_q.err;
    end
  end

  assign valid_o      = valid_q;
  assign stack_word_o = stack_word_q;
  assign last_word_o  = last_word_q;
  assign error_code_o = error_code_q;

endmodule

[test/tb_camac_stack_command_encoder_top.sv]
// ----------------------------------------------------------------------------
// tb_camac_stack_command_encoder_top
// Self-checking bench for the stack command encoder.
// ----------------------------------------------------------------------------
// A queue of pending commands feeds a clocked driver. The queue holds a
// directed set first, then random commands. At every accepted transfer an
// internal encoder works out the stack words that the command must produce
// and queues them. A clocked monitor compares every strobed word, field by
// field, against the oldest queued word.
// ----------------------------------------------------------------------------
module tb_camac_stack_command_encoder_top;
  import csce_pkg::*;

  localparam int ClkPeriod    = 20;
  localparam int ResetCycles  = 12;
  localparam int RandomCmds   = 300;
  localparam int CycleLimit   = 200000;
  localparam int ReportLimit  = 10;
  localparam int IdlePercent  = 35;
  localparam int DrainCycles  = 8;

  // One command as the sender presents it. The opcode stays a plain vector
  // because the undefined codes 10 to 15 are part of the stimulus too.
  typedef struct {
    logic [3:0]  opcode;
    logic [4:0]  slot;
    logic [4:0]  subaddress;
    logic [4:0]  function_code;
    logic [31:0] write_data;
    logic [15:0] transfer_count;
    logic        lam_wait;
    bit          drain_first;  // hold this command until no word is owed
  } command_t;

  // One stack word as it should appear on the result ports.
  typedef struct {
    logic [15:0] word;
    logic        last;
    err_e        err;
  } stack_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  opcode_q = '0;
  logic [4:0]  slot_q = '0;
  logic [4:0]  subaddress_q = '0;
  logic [4:0]  function_code_q = '0;
  logic [31:0] write_data_q = '0;
  logic [15:0] transfer_count_q = '0;
  logic        lam_wait_q = 1'b0;
  logic        valid_o;
  logic [15:0] stack_word_o;
  logic        last_word_o;
  logic [1:0]  error_code_o;

  command_t    pending_cmds[$];
  stack_word_t owed_words[$];
  command_t    presented;
  int          transfers_done = 0;
  int          mismatches = 0;
  int          cycles = 0;

  camac_stack_command_encoder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_q),
    .slot_i          (slot_q),
    .subaddress_i    (subaddress_q),
    .function_code_i (function_code_q),
    .write_data_i    (write_data_q),
    .transfer_count_i(transfer_count_q),
    .lam_wait_i      (lam_wait_q),
    .valid_o         (valid_o),
    .stack_word_o    (stack_word_o),
    .last_word_o     (last_word_o),
    .error_code_o    (error_code_o)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // The checks run in a fixed order: slot, then subaddress, then function.
  // The class ranges fall on bit boundaries of the function code: reads
  // have F[4:3] clear, writes have F[4:3] equal to binary 10, and controls
  // have F[3] set (8 to 15 and 24 to 31).
  function automatic err_e check_command(command_t c);
    if (c.slot >= SlotLimit) return ERR_SLOT;
    if (c.subaddress >= SubaddrLimit) return ERR_SUBADDR;
    case (c.opcode)
      OP_WR16, OP_WR24: return (c.function_code[4:3] == 2'b10) ? ERR_OK : ERR_FUNC;
      OP_CTRL:          return c.function_code[3] ? ERR_OK : ERR_FUNC;
      default:          return (c.function_code[4:3] == 2'b00) ? ERR_OK : ERR_FUNC;
    endcase
  endfunction

  function automatic void owe_word(logic [15:0] word, logic last, err_e err);
    stack_word_t w;
    w.word = word;
    w.last = last;
    w.err  = err;
    owed_words = {owed_words, w};
  endfunction

  // Works out the stack words of one accepted command and queues them.
  function automatic void encode_command(command_t c);
    err_e        err;
    logic [15:0] naf;
    logic [15:0] mode;
    // Undefined opcodes are dropped silently.
    if (c.opcode > OP_MARKER) return;
    // The marker skips every check and ignores N, A and F.
    if (c.opcode == OP_MARKER) begin
      owe_word(MarkerNaf, 1'b0, ERR_OK);
      owe_word(c.write_data[15:0], 1'b1, ERR_OK);
      return;
    end
    err = check_command(c);
    if (err != ERR_OK) begin
      owe_word('0, 1'b1, err);
      return;
    end
    // N sits at bits 13:9, A at 8:5 and F at 4:0.
    naf = {2'b00, c.slot, c.subaddress[3:0], c.function_code};
    case (c.opcode)
      OP_WR16: begin
        owe_word(naf, 1'b0, ERR_OK);
        owe_word(c.write_data[15:0], 1'b1, ERR_OK);
      end
      OP_WR24: begin
        owe_word(naf | LongBit, 1'b0, ERR_OK);
        owe_word(c.write_data[15:0], 1'b0, ERR_OK);
        owe_word(c.write_data[31:16], 1'b1, ERR_OK);
      end
      OP_RD16, OP_RD24: begin
        if (c.opcode == OP_RD24) naf = naf | LongBit;
        // A LAM wait adds a mode word, so the NAF carries continuation.
        if (c.lam_wait) begin
          owe_word(naf | ContBit, 1'b0, ERR_OK);
          owe_word(ModeLam, 1'b1, ERR_OK);
        end else begin
          owe_word(naf, 1'b1, ERR_OK);
        end
      end
      OP_CTRL: owe_word(naf, 1'b1, ERR_OK);
      default: begin
        // Block transfers: NAF with continuation, mode word, then count.
        if (c.opcode == OP_QSTOP24) naf = naf | LongBit;
        if (c.opcode == OP_QSCAN) mode = ModeQscan;
        else if (c.opcode == OP_REPEAT) mode = ModeRepeat;
        else mode = ModeQstop;
        mode = mode | ContBit;
        if (c.lam_wait) mode = mode | ModeLam;
        owe_word(naf | ContBit, 1'b0, ERR_OK);
        owe_word(mode, 1'b0, ERR_OK);
        owe_word(c.transfer_count, 1'b1, ERR_OK);
      end
    endcase
  endfunction

  function automatic void add_command(logic [3:0] op, logic [4:0] n, logic [4:0] a,
                                      logic [4:0] f, logic [31:0] data,
                                      logic [15:0] cnt, logic lam, bit drain);
    command_t c;
    c.opcode         = op;
    c.slot           = n;
    c.subaddress     = a;
    c.function_code  = f;
    c.write_data     = data;
    c.transfer_count = cnt;
    c.lam_wait       = lam;
    c.drain_first    = drain;
    pending_cmds = {pending_cmds, c};
  endfunction

  function automatic void log_mismatch(string what, stack_word_t want, bit have_want);
    mismatches++;
    if (mismatches <= ReportLimit) begin
      if (have_want)
        $display("%s: expected word %h last %b err %0d, got word %h last %b err %0d",
                 what, want.word, want.last, want.err,
                 stack_word_o, last_word_o, error_code_o);
      else
        $display("%s: word %h last %b err %0d", what, stack_word_o, last_word_o,
                 error_code_o);
    end
  endfunction

  // Driver. A command stays on the ports until it is transferred. Between
  // commands the sender idles at random, except through a stretch in the
  // middle of the run, so that gaps land on every phase of the encoder's
  // output. A command flagged drain_first is held back until every owed
  // word has been seen.
  always @(posedge clk_i or negedge rst_ni) begin
    bit go;
    bit quiet;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        encode_command(presented);
        transfers_done++;
      end
      if (!(start && busy)) begin
        quiet = (transfers_done >= 120) && (transfers_done < 200);
        go = (pending_cmds.size() != 0) &&
             (quiet || ($urandom_range(0, 99) >= IdlePercent));
        if (go && pending_cmds[0].drain_first && (owed_words.size() != 0)) go = 1'b0;
        if (go) begin
          presented        = pending_cmds.pop_front();
          opcode_q         <= presented.opcode;
          slot_q           <= presented.slot;
          subaddress_q     <= presented.subaddress;
          function_code_q  <= presented.function_code;
          write_data_q     <= presented.write_data;
          transfer_count_q <= presented.transfer_count;
          lam_wait_q       <= presented.lam_wait;
          start            <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every strobed word must match the oldest owed word.
  always @(posedge clk_i) begin
    stack_word_t want;
    if (rst_ni && valid_o) begin
      if (owed_words.size() == 0) begin
        log_mismatch("unexpected word", want, 1'b0);
      end else begin
        want = owed_words.pop_front();
        if (stack_word_o !== want.word || last_word_o !== want.last ||
            error_code_o !== want.err)
          log_mismatch("wrong word", want, 1'b1);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [3:0]  op;
    logic [4:0]  n;
    logic [4:0]  a;
    logic [4:0]  f;
    int          counted;
    stack_word_t none;

    // Directed part: field extremes, every opcode, both LAM settings,
    // each check failing on its own and with a later check also failing,
    // the marker with junk N, A and F, and undefined opcodes.
    add_command(OP_WR16, 5'd29, 5'd15, 5'd23, 32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b0);
    add_command(OP_WR24, 5'd0, 5'd0, 5'd16, 32'hA5A5_5A5A, 16'hFFFF, 1'b1, 1'b0);
    add_command(OP_RD16, 5'd1, 5'd2, 5'd0, 32'h0, 16'h0, 1'b0, 1'b0);
    add_command(OP_RD16, 5'd29, 5'd15, 5'd7, 32'h0, 16'h0, 1'b1, 1'b0);
    add_command(OP_RD24, 5'd21, 5'd10, 5'd3, 32'h0, 16'h0, 1'b0, 1'b0);
    add_command(OP_RD24, 5'd10, 5'd5, 5'd4, 32'h0, 16'h0, 1'b1, 1'b0);
    add_command(OP_CTRL, 5'd3, 5'd1, 5'd8, 32'h0, 16'h0, 1'b0, 1'b0);
    add_command(OP_CTRL, 5'd4, 5'd9, 5'd15, 32'h0, 16'h0, 1'b1, 1'b0);
    add_command(OP_CTRL, 5'd5, 5'd3, 5'd24, 32'h0, 16'h0, 1'b0, 1'b0);
    add_command(OP_CTRL, 5'd28, 5'd14, 5'd31, 32'h0, 16'h0, 1'b0, 1'b0);
    add_command(OP_QSTOP16, 5'd2, 5'd0, 5'd0, 32'h0, 16'hFFFF, 1'b1, 1'b0);
    add_command(OP_QSTOP24, 5'd12, 5'd7, 5'd2, 32'h0, 16'h0000, 1'b0, 1'b0);
    add_command(OP_QSCAN, 5'd16, 5'd8, 5'd1, 32'h0, 16'h1234, 1'b1, 1'b0);
    add_command(OP_REPEAT, 5'd8, 5'd4, 5'd6, 32'h0, 16'h8001, 1'b0, 1'b0);
    add_command(OP_MARKER, 5'd31, 5'd31, 5'd5, 32'h1234_FFFF, 16'h0, 1'b1, 1'b0);
    add_command(OP_WR16, 5'd30, 5'd0, 5'd16, 32'h0, 16'h0, 1'b0, 1'b0);
    add_command(OP_RD16, 5'd31, 5'd31, 5'd31, 32'h0, 16'h0, 1'b0, 1'b0);
    add_command(OP_RD24, 5'd0, 5'd16, 5'd0, 32'h0, 16'h0, 1'b0, 1'b0);
    add_command(OP_CTRL, 5'd0, 5'd31, 5'd0, 32'h0, 16'h0, 1'b0, 1'b0);
    add_command(OP_WR24, 5'd1, 5'd1, 5'd15, 32'h0, 16'h0, 1'b0, 1'b0);
    add_command(OP_WR16, 5'd1, 5'd1, 5'd24, 32'h0, 16'h0, 1'b0, 1'b0);
    add_command(OP_QSCAN, 5'd1, 5'd1, 5'd8, 32'h0, 16'h0, 1'b1, 1'b0);
    add_command(OP_CTRL, 5'd1, 5'd1, 5'd16, 32'h0, 16'h0, 1'b0, 1'b0);
    add_command(OP_CTRL, 5'd1, 5'd1, 5'd7, 32'h0, 16'h0, 1'b0, 1'b0);
    add_command(4'd10, 5'd1, 5'd1, 5'd1, 32'h0, 16'h0, 1'b0, 1'b0);
    add_command(4'd15, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0);

    // Random part. Most commands pass every check so that all word
    // layouts are exercised; the rest carry raw field values. Undefined
    // opcodes are mixed in but do not count toward the total.
    counted = 0;
    while (counted < RandomCmds) begin
      if ($urandom_range(0, 99) < 4) begin
        op = 4'($urandom_range(10, 15));
      end else begin
        op = 4'($urandom_range(0, 9));
        counted++;
      end
      n = 5'($urandom);
      a = 5'($urandom);
      f = 5'($urandom);
      if ($urandom_range(0, 99) < 70) begin
        n = 5'($urandom_range(0, 29));
        a = 5'($urandom_range(0, 15));
        case (op)
          OP_WR16, OP_WR24: f = {2'b10, 3'($urandom)};
          OP_CTRL:          f = {1'($urandom), 1'b1, 3'($urandom)};
          default:          f = {2'b00, 3'($urandom)};
        endcase
      end
      add_command(op, n, a, f, $urandom, 16'($urandom), 1'($urandom),
                  (counted == 1) || ($urandom_range(0, 99) < 2));
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every command to be transferred, then for every owed word.
    @(posedge clk_i);
    while (pending_cmds.size() != 0 || start) @(posedge clk_i);
    while (owed_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    while (owed_words.size() != 0) begin
      none = owed_words.pop_front();
      mismatches++;
      if (mismatches <= ReportLimit)
        $display("missing word %h last %b err %0d", none.word, none.last, none.err);
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
